// ===== rtl/lvnt_pkg.sv =====
package lvnt_pkg;

	localparam int TABLE_AW  = 8;
	localparam int NOISE_W   = 16;
	localparam int PERM_W    = 8;
	localparam int COORD_W   = 32;
	localparam int SCALE_W   = 24;
	localparam int OCT_W     = 4;
	localparam int MAX_OCT   = 8;
	localparam int FRAC_W    = 16;
	localparam int POINT_W   = 28;
	localparam int ACC_W     = 26;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;

	localparam logic [1:0] REQ_NOISE = 2'd0;
	localparam logic [1:0] REQ_PERM  = 2'd1;
	localparam logic [1:0] REQ_EVAL  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OCTAVE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd2;

	localparam logic [63:0] OFFSET_Q = 64'd10000 << POINT_W;

	typedef struct packed {
		logic              start;
		logic [2:0]        oct;
		logic              last;
	} lvnt_cmd_t;

	typedef struct packed {
		logic done;
	} lvnt_sts_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [TABLE_AW-1:0] table_index;
		logic [15:0]        table_value;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} lvnt_req_t;

	function automatic logic [NOISE_W-1:0] blend(logic [NOISE_W-1:0] a,
			logic [NOISE_W-1:0] b, logic [FRAC_W-1:0] t);
		logic [FRAC_W:0] one_t;
		logic [33:0] s;
		one_t = (17'd1 << FRAC_W) - {1'b0, t};
		s = 34'(a * one_t) + 34'(b * t) + 34'(17'd1 << (FRAC_W - 1));
		return s[FRAC_W +: NOISE_W];
	endfunction

endpackage

// ===== rtl/lvnt_if.sv =====
interface lvnt_req_if;
	import lvnt_pkg::*;
	logic      valid;
	logic      ready;
	lvnt_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface lvnt_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] noise_value;
	modport source (output valid, output noise_value, input ready);
	modport sink (input valid, input noise_value, output ready);
endinterface

interface lvnt_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lattice_value_noise_turbulence.sv =====
// 3D lattice value noise with optional octave turbulence.
// req channel: req_type 0 loads a noise table entry, 1 a permutation
// entry (low 8 bits), 2 evaluates at coord_x/y/z (signed Q16.16).
// Loads give no word; type 3 is dropped.
// rsp channel: one noise_value word (unsigned Q0.16) per evaluate.
// cfg channel: index 0 turbulence_mode, 1 octave_count, 2 base_scale;
// not ready while an evaluate runs.
// Per octave: a start step, a scale multiply and split for each of the
// x, y and z axes, the two z hashes, 8 corners of serialized single-port
// table reads (y hash, x hash and noise read for a new y/z pair; x hash
// and noise read when the y hash is reused), blends along x, y and z and
// a done step. The word follows the last octave; octaves is 1, or
// octave_count capped at 8 in turbulence mode (0 octaves gives a zero word).
// One evaluate in flight at a time; req is not ready while a result
// waits, so a stalled receiver holds off the next word.
// Reset puts registers to mode 0, 3 octaves, scale 1.0; tables are
// undefined until loaded.
module lattice_value_noise_turbulence
	import lvnt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	lvnt_req_if.sink   req,
	lvnt_rsp_if.source rsp,
	lvnt_cfg_if.sink   cfg
);

	logic               mode_q;
	logic [OCT_W-1:0]   oct_cnt_q;
	logic [SCALE_W-1:0] scale_q;
	logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
	lvnt_cmd_t cmd;
	lvnt_sts_t sts;
	logic [NOISE_W-1:0] sample;
	logic wr_noise, wr_perm, busy;

	assign cfg.ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			oct_cnt_q <= 4'd3;
			scale_q   <= 24'd4096;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MODE:   mode_q    <= cfg.data[0];
				REG_OCTAVE: oct_cnt_q <= cfg.data[OCT_W-1:0];
				REG_SCALE:  scale_q   <= cfg.data;
				default: ;
			endcase
		end
	end

	// coordinates held for the whole evaluate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
		end else if (req.valid && req.ready && req.data.req_type == REQ_EVAL) begin
			cx_q <= req.data.coord_x;
			cy_q <= req.data.coord_y;
			cz_q <= req.data.coord_z;
		end
	end

	lvnt_ctrl u_ctrl (
		.clk, .arst_n, .req, .rsp,
		.turb_mode(mode_q), .oct_count(oct_cnt_q),
		.cmd, .sts, .sample, .wr_noise, .wr_perm, .busy
	);

	lvnt_datapath u_dp (
		.clk, .arst_n, .cmd, .sts,
		.wr_noise, .wr_perm,
		.wr_index(req.data.table_index), .wr_value(req.data.table_value),
		.cx(cx_q), .cy(cy_q), .cz(cz_q),
		.scale(scale_q), .sample
	);

endmodule

// ===== rtl/lvnt_datapath.sv =====
module lvnt_datapath
	import lvnt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  lvnt_cmd_t           cmd,
	output lvnt_sts_t           sts,
	input  logic                wr_noise,
	input  logic                wr_perm,
	input  logic [TABLE_AW-1:0] wr_index,
	input  logic [15:0]         wr_value,
	input  logic signed [COORD_W-1:0] cx,
	input  logic signed [COORD_W-1:0] cy,
	input  logic signed [COORD_W-1:0] cz,
	input  logic [SCALE_W-1:0]  scale,
	output logic [NOISE_W-1:0]  sample
);

	typedef enum logic [9:0] {
		D_IDLE  = 10'b0000000001,
		D_MUL   = 10'b0000000010,
		D_SPLIT = 10'b0000000100,
		D_PZ    = 10'b0000001000,
		D_PY    = 10'b0000010000,
		D_PX    = 10'b0000100000,
		D_NV    = 10'b0001000000,
		D_BX    = 10'b0010000000,
		D_BY    = 10'b0100000000,
		D_BZ    = 10'b1000000000
	} dstate_t;

	dstate_t state_q;
	logic [PERM_W-1:0]  perm_mem [2**TABLE_AW];
	logic [NOISE_W-1:0] noise_mem [2**TABLE_AW];
	logic [PERM_W-1:0]  perm_rd_q;
	logic [NOISE_W-1:0] noise_rd_q;
	logic [TABLE_AW-1:0] perm_addr, noise_addr;
	logic [1:0]  axis_q;
	logic [2:0]  corner_q;
	logic [1:0]  wait_q;
	logic [63:0] prod_q;
	logic [TABLE_AW-1:0] ip_q [3];
	logic [FRAC_W-1:0]   fr_q [3];
	logic [PERM_W-1:0]   pz_q [2];
	logic [PERM_W-1:0]   py_q;
	logic [NOISE_W-1:0]  d_q [8];
	logic [NOISE_W-1:0]  bx_q [4];
	logic [NOISE_W-1:0]  by_q [2];
	logic [2:0] oct_q;
	logic signed [COORD_W-1:0] axis_c;
	logic [63:0] shifted;

	always_comb begin
		case (axis_q)
			2'd0:    axis_c = cx;
			2'd1:    axis_c = cy;
			default: axis_c = cz;
		endcase
	end

	assign shifted = (prod_q << oct_q) + OFFSET_Q;

	always_comb begin
		perm_addr = ip_q[2] + TABLE_AW'(corner_q[2]);
		case (state_q)
			D_PY:    perm_addr = ip_q[1] + TABLE_AW'(corner_q[1]) + pz_q[corner_q[2]];
			D_PX:    perm_addr = ip_q[0] + TABLE_AW'(corner_q[0]) + py_q;
			default: perm_addr = ip_q[2] + TABLE_AW'(corner_q[2]);
		endcase
	end
	assign noise_addr = perm_rd_q;

	always_ff @(posedge clk) begin
		if (wr_perm) begin
			perm_mem[wr_index] <= wr_value[PERM_W-1:0];
		end
		if (wr_noise) begin
			noise_mem[wr_index] <= wr_value;
		end
		perm_rd_q  <= perm_mem[perm_addr];
		noise_rd_q <= noise_mem[noise_addr];
	end

	// sequencer: one table read in flight, each dependent read waiting for the one before
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= D_IDLE;
			axis_q   <= '0;
			corner_q <= '0;
			wait_q   <= '0;
			oct_q    <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (cmd.start) begin
						oct_q  <= cmd.oct;
						axis_q <= '0;
						state_q <= D_MUL;
					end
				end
				D_MUL: state_q <= D_SPLIT;
				D_SPLIT: begin
					if (axis_q == 2'd2) begin
						axis_q   <= '0;
						corner_q <= '0;
						wait_q   <= '0;
						state_q  <= D_PZ;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= D_MUL;
					end
				end
				D_PZ: begin
					wait_q <= wait_q + 2'd1;
					if (wait_q == 2'd1) begin
						wait_q <= '0;
						if (corner_q[2]) begin
							corner_q <= '0;
							state_q  <= D_PY;
						end else begin
							corner_q <= 3'd4;
						end
					end
				end
				D_PY: begin
					wait_q <= wait_q + 2'd1;
					if (wait_q == 2'd1) begin
						wait_q  <= '0;
						state_q <= D_PX;
					end
				end
				D_PX: begin
					wait_q <= wait_q + 2'd1;
					if (wait_q == 2'd1) begin
						wait_q  <= '0;
						state_q <= D_NV;
					end
				end
				D_NV: begin
					wait_q <= wait_q + 2'd1;
					if (wait_q == 2'd1) begin
						wait_q <= '0;
						if (corner_q == 3'd7) begin
							state_q <= D_BX;
						end else begin
							corner_q <= corner_q + 3'd1;
							// same y/z pair reuses the y hash
							state_q  <= corner_q[0] ? D_PY : D_PX;
						end
					end
				end
				D_BX: state_q <= D_BY;
				D_BY: state_q <= D_BZ;
				D_BZ: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_MUL: prod_q <= 64'($signed(axis_c) * $signed({1'b0, scale}));
			D_SPLIT: begin
				ip_q[axis_q] <= shifted[POINT_W +: TABLE_AW];
				fr_q[axis_q] <= shifted[POINT_W-FRAC_W +: FRAC_W];
			end
			D_PZ: if (wait_q == 2'd1) pz_q[corner_q[2]] <= perm_rd_q;
			D_PY: if (wait_q == 2'd1) py_q <= perm_rd_q;
			D_NV: if (wait_q == 2'd1) d_q[corner_q] <= noise_rd_q;
			D_BX: begin
				bx_q[0] <= blend(d_q[0], d_q[1], fr_q[0]);
				bx_q[1] <= blend(d_q[2], d_q[3], fr_q[0]);
				bx_q[2] <= blend(d_q[4], d_q[5], fr_q[0]);
				bx_q[3] <= blend(d_q[6], d_q[7], fr_q[0]);
			end
			D_BY: begin
				by_q[0] <= blend(bx_q[0], bx_q[1], fr_q[1]);
				by_q[1] <= blend(bx_q[2], bx_q[3], fr_q[1]);
			end
			D_BZ: sample <= blend(by_q[0], by_q[1], fr_q[2]);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sts.done <= 1'b0;
		end else begin
			sts.done <= (state_q == D_BZ);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && state_q == D_IDLE |=> state_q == D_MUL)
		else $error("sample did not start");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == D_BZ |=> sts.done && state_q == D_IDLE)
		else $error("done not raised after final blend");
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> !$past(sts.done))
		else $error("done held longer than one cycle");

endmodule

// ===== rtl/lvnt_ctrl.sv =====
module lvnt_ctrl
	import lvnt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	lvnt_req_if.sink         req,
	lvnt_rsp_if.source       rsp,
	input  logic             turb_mode,
	input  logic [OCT_W-1:0] oct_count,
	output lvnt_cmd_t        cmd,
	input  lvnt_sts_t        sts,
	input  logic [NOISE_W-1:0] sample,
	output logic             wr_noise,
	output logic             wr_perm,
	output logic             busy
);

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_RUN  = 4'b0010,
		C_WAIT = 4'b0100,
		C_OUT  = 4'b1000
	} cstate_t;

	cstate_t state_q;
	logic [3:0] oct_q, n_q;
	logic [ACC_W-1:0] acc_q;
	logic [ACC_W-1:0] acc_next;
	logic [ACC_W-1:0] rounded;
	logic [3:0] n_sel;
	logic accept;

	assign req.ready = (state_q == C_IDLE) && !rsp.valid;
	assign accept = req.valid && req.ready;
	assign wr_noise = accept && req.data.req_type == REQ_NOISE;
	assign wr_perm  = accept && req.data.req_type == REQ_PERM;
	assign busy = state_q != C_IDLE;
	assign n_sel = !turb_mode ? 4'd1 :
		(oct_count > OCT_W'(MAX_OCT)) ? OCT_W'(MAX_OCT) : oct_count;
	assign acc_next = acc_q + (ACC_W'(sample) << (MAX_OCT - 32'(oct_q)));
	assign rounded = (acc_q + ACC_W'(1 << MAX_OCT)) >> (MAX_OCT + 1);

	always_comb begin
		cmd.start = (state_q == C_RUN);
		cmd.oct   = oct_q[2:0];
		cmd.last  = (oct_q + 4'd1 == n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rsp.valid <= 1'b0;
			rsp.noise_value <= '0;
			oct_q <= '0;
			n_q <= '0;
			acc_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp.valid <= 1'b0;
			end
			case (state_q)
				C_IDLE: begin
					if (accept && req.data.req_type == REQ_EVAL) begin
						oct_q <= '0;
						n_q   <= n_sel;
						acc_q <= '0;
						state_q <= (n_sel == 4'd0) ? C_OUT : C_RUN;
					end
				end
				C_RUN: state_q <= C_WAIT;
				C_WAIT: begin
					if (sts.done) begin
						if (!turb_mode) begin
							acc_q <= ACC_W'(sample);
						end else begin
							acc_q <= acc_next;
						end
						oct_q <= oct_q + 4'd1;
						state_q <= cmd.last ? C_OUT : C_RUN;
					end
				end
				C_OUT: begin
					rsp.valid <= 1'b1;
					if (!turb_mode) begin
						rsp.noise_value <= acc_q[NOISE_W-1:0];
					end else if (rounded > ACC_W'(16'hFFFF)) begin
						rsp.noise_value <= 16'hFFFF;
					end else begin
						rsp.noise_value <= rounded[NOISE_W-1:0];
					end
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == C_OUT |=> rsp.valid)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> state_q == C_WAIT)
		else $error("unexpected sample done");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !req.ready)
		else $error("ready while busy");

endmodule
